// ===== src/plnk_pkg.sv =====
package plnk_pkg;

  // Index fields are sized for the largest supported store (4096 entries).
  localparam int IDX_W = 12;

  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_FIND   = 3'd3,
    CMD_GET    = 3'd4,
    CMD_LENGTH = 3'd5
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    WM_UP,
    WM_DOWN,
    WM_SCAN,
    WM_READ
  } walk_mode_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] position;
    logic [7:0] element;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] value;
    logic [6:0] found_position;
    logic [6:0] length;
  } out_item_t;

  typedef struct packed {
    walk_mode_t       mode;
    logic             empty;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] last;
    logic [IDX_W-1:0] slot;
    logic [7:0]       key;
  } walk_req_t;

  typedef struct packed {
    logic             done;
    logic             hit;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
  } walk_rsp_t;

endpackage

// ===== src/plnk_ram.sv =====
module plnk_ram #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/plnk_walk.sv =====
module plnk_walk #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  plnk_pkg::walk_req_t req,
  output plnk_pkg::walk_rsp_t rsp,
  output logic                ram_we,
  output logic [AW-1:0]       ram_waddr,
  output logic [7:0]          ram_wdata,
  output logic [AW-1:0]       ram_raddr,
  input  logic [7:0]          ram_rdata
);
  import plnk_pkg::*;

  typedef enum logic [1:0] {
    W_IDLE,
    W_RUN,
    W_WAIT,
    W_TAIL
  } wstate_t;

  wstate_t    state_r;
  walk_mode_t mode_r;
  logic [7:0] key_r;
  logic [AW-1:0] slot_r;
  logic [AW-1:0] rd_addr_r;
  logic [AW-1:0] last_addr_r;
  logic [AW-1:0] pend_addr_r;
  logic          pend_r;
  walk_rsp_t     rsp_r;

  logic issue;
  logic hit;

  assign issue     = (state_r == W_RUN);
  assign hit       = pend_r && (mode_r == WM_SCAN) && (ram_rdata == key_r);
  assign ram_raddr = rd_addr_r;

  // Reads always run ahead of writes in the walk direction, so an entry is
  // never read after it has been overwritten: no forwarding is needed.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_addr_r;
    ram_wdata = ram_rdata;
    if (state_r == W_TAIL) begin
      ram_we    = 1'b1;
      ram_waddr = slot_r;
      ram_wdata = key_r;
    end else if (pend_r && mode_r == WM_UP) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr_r + AW'(1);
    end else if (pend_r && mode_r == WM_DOWN) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr_r - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= W_IDLE;
      pend_r   <= 1'b0;
      rsp_r    <= '0;
    end else begin
      rsp_r.done  <= 1'b0;
      pend_r      <= issue && !hit;
      pend_addr_r <= rd_addr_r;
      unique case (state_r)
        W_IDLE: begin
          if (go) begin
            mode_r      <= req.mode;
            key_r       <= req.key;
            slot_r      <= req.first[AW-1:0] == req.first[AW-1:0] ? req.slot[AW-1:0]
                                                                  : req.slot[AW-1:0];
            rd_addr_r   <= req.first[AW-1:0];
            last_addr_r <= req.last[AW-1:0];
            rsp_r.hit   <= 1'b0;
            if (!req.empty) begin
              state_r <= W_RUN;
            end else if (req.mode == WM_UP) begin
              state_r <= W_TAIL;
            end else begin
              rsp_r.done <= 1'b1;
            end
          end
        end
        W_RUN: begin
          if (hit) begin
            rsp_r.done <= 1'b1;
            rsp_r.hit  <= 1'b1;
            rsp_r.idx  <= IDX_W'(pend_addr_r);
            state_r    <= W_IDLE;
          end else if (rd_addr_r == last_addr_r) begin
            state_r <= W_WAIT;
          end else if (mode_r == WM_UP) begin
            rd_addr_r <= rd_addr_r - AW'(1);
          end else begin
            rd_addr_r <= rd_addr_r + AW'(1);
          end
        end
        W_WAIT: begin
          // last read returns now
          rsp_r.hit  <= hit;
          rsp_r.idx  <= IDX_W'(pend_addr_r);
          rsp_r.data <= ram_rdata;
          if (mode_r == WM_UP) begin
            state_r <= W_TAIL;
          end else begin
            rsp_r.done <= 1'b1;
            state_r    <= W_IDLE;
          end
        end
        W_TAIL: begin
          rsp_r.done <= 1'b1;
          state_r    <= W_IDLE;
        end
        default: state_r <= W_IDLE;
      endcase
    end
  end

  assign rsp = rsp_r;

endmodule

// ===== src/positional_char_list_engine.sv =====
// Channel  Ports                      Transfer when
// -------  -------------------------  ----------------------------
// input    start, busy, in_item       start high and busy low
// result   out_valid, out_item        out_valid high (one cycle)
//
// Length, every error case, undefined codes and find on an empty list answer
// in the cycle after the transfer. The rest walks the list memory (separate
// read/write ports) one entry per cycle: get reads one, insert/push shift the
// tail up from p, delete shifts it down onto p, find scans to the first match.
// Synchronous reset empties the list; memory contents are not cleared.
// Results are strobed and cannot be stalled; busy holds off new commands.
module positional_char_list_engine #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  plnk_pkg::in_item_t  in_item,
  output logic                out_valid,
  output plnk_pkg::out_item_t out_item
);
  import plnk_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > 8 ? CW : 8) + 1;

  logic          busy_r;
  logic [CW-1:0] count_r;
  walk_mode_t    mode_r;
  logic          out_valid_r;
  out_item_t     out_r;

  logic          accept;
  logic          launch;
  walk_req_t     req;
  out_item_t     imm_res;
  out_item_t     done_res;
  logic [CW-1:0] count_nxt;
  walk_rsp_t     rsp;

  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic [XW-1:0] at_x;
  logic [XW-1:0] ins_x;
  logic          full;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  assign accept = start && !busy_r;
  assign pos_x  = XW'(in_item.position);
  assign cnt_x  = XW'(count_r);
  assign at_x   = pos_x - XW'(1);
  assign full   = (count_r == CW'(CAPACITY));

  always_comb begin
    launch    = 1'b0;
    ins_x     = (in_item.command == CMD_PUSH) ? '0 : at_x;
    req.mode  = WM_READ;
    req.empty = 1'b0;
    req.first = IDX_W'(at_x);
    req.last  = IDX_W'(at_x);
    req.slot  = IDX_W'(ins_x);
    req.key   = in_item.element;
    imm_res   = '{status: ST_OK, value: '0, found_position: '0, length: 7'(count_r)};
    unique case (in_item.command) inside
      CMD_PUSH, CMD_INSERT: begin
        if (in_item.command == CMD_INSERT &&
            (pos_x == '0 || pos_x > cnt_x + XW'(1))) begin
          imm_res.status = ST_BADPOS;
        end else if (full) begin
          imm_res.status = ST_FULL;
        end else begin
          launch    = 1'b1;
          req.mode  = WM_UP;
          req.empty = (cnt_x == ins_x);
          req.first = IDX_W'(cnt_x - XW'(1));
          req.last  = IDX_W'(ins_x);
        end
      end
      CMD_DELETE: begin
        if (pos_x == '0 || pos_x > cnt_x) begin
          imm_res.status = ST_BADPOS;
        end else begin
          launch    = 1'b1;
          req.mode  = WM_DOWN;
          req.empty = (at_x == cnt_x - XW'(1));
          req.first = IDX_W'(at_x + XW'(1));
          req.last  = IDX_W'(cnt_x - XW'(1));
        end
      end
      CMD_FIND: begin
        if (count_r == '0) begin
          imm_res.status = ST_NOTFOUND;
        end else begin
          launch    = 1'b1;
          req.mode  = WM_SCAN;
          req.first = '0;
          req.last  = IDX_W'(cnt_x - XW'(1));
        end
      end
      CMD_GET: begin
        if (pos_x == '0 || pos_x > cnt_x) begin
          imm_res.status = ST_BADPOS;
        end else begin
          launch = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    done_res  = '{status: ST_OK, value: '0, found_position: '0, length: 7'(count_r)};
    unique case (mode_r)
      WM_UP:   count_nxt = count_r + CW'(1);
      WM_DOWN: count_nxt = count_r - CW'(1);
      WM_SCAN: begin
        if (rsp.hit) begin
          done_res.found_position = 7'(CW'(rsp.idx[AW-1:0]) + CW'(1));
        end else begin
          done_res.status = ST_NOTFOUND;
        end
      end
      WM_READ: done_res.value = rsp.data;
      default: count_nxt = count_r;
    endcase
    done_res.length = 7'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (accept) begin
        if (launch) begin
          busy_r <= 1'b1;
          mode_r <= req.mode;
        end else begin
          out_valid_r <= 1'b1;
          out_r       <= imm_res;
        end
      end
      if (rsp.done) begin
        busy_r      <= 1'b0;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
        out_r       <= done_res;
      end
    end
  end

  plnk_walk #(.DEPTH(CAPACITY)) u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (accept && launch),
    .req       (req),
    .rsp       (rsp),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  plnk_ram #(.DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== src/plnk_chk.sv =====
module plnk_chk #(
  parameter int CAPACITY = 64
) (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input plnk_pkg::out_item_t out_item
);
  import plnk_pkg::*;

  // a transfer yields a result next cycle or starts a walk
  a_accept_leads: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid || busy)
    else $error("accepted command produced neither result nor busy");

  // the walk ends exactly with its result
  a_busy_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.found_position != '0 || out_item.value != '0)
      |-> out_item.status == ST_OK)
    else $error("payload data on an error result");

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_FULL |-> out_item.length == 7'(CAPACITY))
    else $error("store full reported below capacity");

endmodule

bind positional_char_list_engine plnk_chk #(.CAPACITY(CAPACITY)) u_plnk_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

// ===== test/positional_char_list_engine_tb.sv =====
`timescale 1ns / 1ps

module positional_char_list_engine_tb;
  import plnk_pkg::*;

  localparam int CAPACITY     = 64;
  localparam int RANDOM_ITEMS = 400;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t reply;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  // Shadow copy of the list, advanced once per accepted command
  logic [7:0] shadow_list [CAPACITY];
  int         shadow_len;

  out_item_t  pending_replies[$];
  dir_row_t   dir_rows[$];
  int         errors;
  int         sent;
  int         checked;
  int         full_replies;
  int         quiet_cycles;

  positional_char_list_engine #(.CAPACITY(CAPACITY)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic in_item_t mk_cmd(logic [2:0] cmd, logic [7:0] pos, logic [7:0] elem);
    in_item_t it;
    it.command  = cmd;
    it.position = pos;
    it.element  = elem;
    return it;
  endfunction

  function automatic out_item_t mk_reply(status_t st, logic [7:0] val, logic [6:0] fpos,
                                         logic [6:0] len);
    out_item_t r;
    r.status         = st;
    r.value          = val;
    r.found_position = fpos;
    r.length         = len;
    return r;
  endfunction

  function automatic out_item_t apply_list_cmd(in_item_t it);
    out_item_t r;
    int        p;
    int        k;
    r = mk_reply(ST_OK, 8'd0, 7'd0, 7'd0);
    p = it.position;
    case (it.command)
      CMD_PUSH: begin
        if (shadow_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (k = shadow_len; k > 0; k--) shadow_list[k] = shadow_list[k-1];
          shadow_list[0] = it.element;
          shadow_len++;
        end
      end
      CMD_INSERT: begin
        // position check wins over the full check
        if (p < 1 || p > shadow_len + 1) begin
          r.status = ST_BADPOS;
        end else if (shadow_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (k = shadow_len; k > p - 1; k--) shadow_list[k] = shadow_list[k-1];
          shadow_list[p-1] = it.element;
          shadow_len++;
        end
      end
      CMD_DELETE: begin
        if (p < 1 || p > shadow_len) begin
          r.status = ST_BADPOS;
        end else begin
          for (k = p - 1; k + 1 < shadow_len; k++) shadow_list[k] = shadow_list[k+1];
          shadow_len--;
        end
      end
      CMD_FIND: begin
        r.status = ST_NOTFOUND;
        for (k = 0; k < shadow_len; k++) begin
          if (shadow_list[k] == it.element) begin
            r.status         = ST_OK;
            r.found_position = 7'(k + 1);
            break;
          end
        end
      end
      CMD_GET: begin
        if (p < 1 || p > shadow_len) r.status = ST_BADPOS;
        else r.value = shadow_list[p-1];
      end
      default: ;
    endcase
    r.length = 7'(shadow_len);
    return r;
  endfunction

  // Mostly legal positions and a small value pool so find hits often
  function automatic in_item_t pick_list_cmd(bit grow);
    in_item_t it;
    int       w;
    w = $urandom_range(99);
    if (grow) begin
      if (w < 25)      it.command = CMD_PUSH;
      else if (w < 50) it.command = CMD_INSERT;
      else if (w < 60) it.command = CMD_DELETE;
      else if (w < 75) it.command = CMD_FIND;
      else if (w < 90) it.command = CMD_GET;
      else if (w < 96) it.command = CMD_LENGTH;
      else             it.command = 3'($urandom_range(7, 6));
    end else begin
      if (w < 8)       it.command = CMD_PUSH;
      else if (w < 20) it.command = CMD_INSERT;
      else if (w < 55) it.command = CMD_DELETE;
      else if (w < 72) it.command = CMD_FIND;
      else if (w < 90) it.command = CMD_GET;
      else if (w < 96) it.command = CMD_LENGTH;
      else             it.command = 3'($urandom_range(7, 6));
    end
    if ($urandom_range(4) == 0)
      it.position = 8'($urandom_range(255));
    else if (it.command == CMD_INSERT)
      it.position = 8'($urandom_range(shadow_len + 1, 1));
    else if (shadow_len == 0)
      it.position = 8'd1;
    else
      it.position = 8'($urandom_range(shadow_len, 1));
    if ($urandom_range(1) == 0) it.element = 8'($urandom_range(7));
    else it.element = 8'($urandom());
    return it;
  endfunction

  task automatic send_cmd(in_item_t it, bit typed, out_item_t reply);
    out_item_t pred;
    in_item = it;
    start   = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    pred = apply_list_cmd(it);
    if (pred.status == ST_FULL) full_replies++;
    pending_replies.push_back(typed ? reply : pred);
    sent++;
    @(negedge clk);
  endtask

  task automatic idle_gap(int n);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain_replies();
    start = 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
  endtask

  task automatic add_row(in_item_t it, bit typed, out_item_t reply);
    dir_row_t row;
    row.item  = it;
    row.typed = typed;
    row.reply = reply;
    dir_rows.push_back(row);
  endtask

  task automatic run_rows();
    foreach (dir_rows[i]) send_cmd(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].reply);
    dir_rows.delete();
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_replies.size() == 0) begin
        errors++;
        $display("%0t: reply with none pending: %p", $time, out_item);
      end else begin
        want = pending_replies.pop_front();
        checked++;
        if (out_item.status !== want.status) begin
          errors++;
          $display("%0t: status exp %0d got %0d", $time, want.status, out_item.status);
        end
        if (out_item.value !== want.value) begin
          errors++;
          $display("%0t: value exp %0d got %0d", $time, want.value, out_item.value);
        end
        if (out_item.found_position !== want.found_position) begin
          errors++;
          $display("%0t: found_position exp %0d got %0d", $time, want.found_position,
                   out_item.found_position);
        end
        if (out_item.length !== want.length) begin
          errors++;
          $display("%0t: length exp %0d got %0d", $time, want.length, out_item.length);
        end
      end
    end
  end

  // Watchdog: end the run if neither channel transfers for too long
  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_item_t it;
    errors       = 0;
    sent         = 0;
    checked      = 0;
    full_replies = 0;
    quiet_cycles = 0;
    shadow_len   = 0;
    start        = 1'b0;
    in_item      = '0;
    rst_n        = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Empty list, bad positions, extremes of position and element
    add_row(mk_cmd(CMD_LENGTH, 8'd0, 8'd0),   1, mk_reply(ST_OK, 8'd0, 7'd0, 7'd0));
    add_row(mk_cmd(CMD_GET, 8'd1, 8'd0),      1, mk_reply(ST_BADPOS, 8'd0, 7'd0, 7'd0));
    add_row(mk_cmd(CMD_DELETE, 8'd1, 8'd0),   1, mk_reply(ST_BADPOS, 8'd0, 7'd0, 7'd0));
    add_row(mk_cmd(CMD_FIND, 8'd0, 8'h55),    1, mk_reply(ST_NOTFOUND, 8'd0, 7'd0, 7'd0));
    add_row(mk_cmd(CMD_INSERT, 8'd0, 8'h01),  1, mk_reply(ST_BADPOS, 8'd0, 7'd0, 7'd0));
    add_row(mk_cmd(CMD_INSERT, 8'd2, 8'h01),  1, mk_reply(ST_BADPOS, 8'd0, 7'd0, 7'd0));
    add_row(mk_cmd(CMD_PUSH, 8'hFF, 8'hFF),   1, mk_reply(ST_OK, 8'd0, 7'd0, 7'd1));
    add_row(mk_cmd(CMD_PUSH, 8'd0, 8'h00),    1, mk_reply(ST_OK, 8'd0, 7'd0, 7'd2));
    add_row(mk_cmd(CMD_INSERT, 8'd3, 8'h80),  0, '0);
    add_row(mk_cmd(CMD_INSERT, 8'd1, 8'h7F),  0, '0);
    add_row(mk_cmd(CMD_GET, 8'd1, 8'hAA),     1, mk_reply(ST_OK, 8'h7F, 7'd0, 7'd4));
    add_row(mk_cmd(CMD_GET, 8'd4, 8'd0),      0, '0);
    add_row(mk_cmd(CMD_GET, 8'd5, 8'd0),      1, mk_reply(ST_BADPOS, 8'd0, 7'd0, 7'd4));
    add_row(mk_cmd(CMD_GET, 8'd255, 8'hFF),   1, mk_reply(ST_BADPOS, 8'd0, 7'd0, 7'd4));
    add_row(mk_cmd(CMD_GET, 8'd0, 8'd0),      1, mk_reply(ST_BADPOS, 8'd0, 7'd0, 7'd4));
    add_row(mk_cmd(CMD_FIND, 8'd0, 8'hFF),    0, '0);
    add_row(mk_cmd(CMD_FIND, 8'd9, 8'h12),    1, mk_reply(ST_NOTFOUND, 8'd0, 7'd0, 7'd4));
    add_row(mk_cmd(CMD_DELETE, 8'd0, 8'd0),   1, mk_reply(ST_BADPOS, 8'd0, 7'd0, 7'd4));
    add_row(mk_cmd(CMD_DELETE, 8'd5, 8'd0),   1, mk_reply(ST_BADPOS, 8'd0, 7'd0, 7'd4));
    add_row(mk_cmd(CMD_DELETE, 8'd4, 8'd0),   0, '0);
    add_row(mk_cmd(CMD_DELETE, 8'd1, 8'd0),   0, '0);
    add_row(mk_cmd(3'd6, 8'h5A, 8'hA5),       1, mk_reply(ST_OK, 8'd0, 7'd0, 7'd2));
    add_row(mk_cmd(3'd7, 8'hFF, 8'hFF),       1, mk_reply(ST_OK, 8'd0, 7'd0, 7'd2));
    run_rows();

    // Append distinct values up to capacity, then hit the full store
    while (shadow_len < CAPACITY)
      send_cmd(mk_cmd(CMD_INSERT, 8'(shadow_len + 1), 8'(shadow_len) | 8'h80), 0, '0);
    add_row(mk_cmd(CMD_PUSH, 8'd0, 8'h11),    1, mk_reply(ST_FULL, 8'd0, 7'd0, 7'd64));
    add_row(mk_cmd(CMD_INSERT, 8'd65, 8'h11), 1, mk_reply(ST_FULL, 8'd0, 7'd0, 7'd64));
    add_row(mk_cmd(CMD_INSERT, 8'd66, 8'h11), 1, mk_reply(ST_BADPOS, 8'd0, 7'd0, 7'd64));
    add_row(mk_cmd(CMD_INSERT, 8'd1, 8'h11),  1, mk_reply(ST_FULL, 8'd0, 7'd0, 7'd64));
    add_row(mk_cmd(CMD_FIND, 8'd0, 8'hBF),    1, mk_reply(ST_OK, 8'd0, 7'd64, 7'd64));
    add_row(mk_cmd(CMD_GET, 8'd64, 8'd0),     1, mk_reply(ST_OK, 8'hBF, 7'd0, 7'd64));
    add_row(mk_cmd(CMD_DELETE, 8'd64, 8'd0),  0, '0);
    add_row(mk_cmd(CMD_DELETE, 8'd1, 8'd0),   0, '0);
    run_rows();

    // Alternate growing and shrinking stretches of random traffic
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) drain_replies();
      if (i < RANDOM_ITEMS - 100 && (i % 100) >= 20 && $urandom_range(3) == 0)
        idle_gap($urandom_range(14, 1));
      it = pick_list_cmd((i / 100) % 2 == 0);
      send_cmd(it, 0, '0);
    end

    drain_replies();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d list commands (directed, fill to capacity, random); %0d replies checked",
             sent, checked);
    $display("Store-full replies: %0d, mismatches: %0d", full_replies, errors);
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      if (pending_replies.size() != 0)
        $display("%0t: %0d replies never arrived", $time, pending_replies.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/plnk_pkg.sv
src/plnk_ram.sv
src/plnk_walk.sv
src/positional_char_list_engine.sv
src/plnk_chk.sv
test/positional_char_list_engine_tb.sv
